/* hdl/trst_pkg.sv */
// Shared types, constants and code tables for the tri-state remote switch transmitter.
// Holds the per-socket digit tables and the segment length lookup.
// No dependencies; used by the core and its checker.
package trst_pkg;

    // Field and port widths
    localparam int SOCK_W        = 3;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 12;
    localparam int PERIOD_W      = 12;
    localparam int REPEAT_W      = 4;
    localparam int PERIODS_W     = 5;
    localparam int DIGIT_IDX_W   = 4;
    localparam int SEG_W         = 2;
    localparam int ROW_W         = 2;
    localparam int INPUT_SOCKETS = 4;

    // Socket numbering and list defaults
    localparam int SOCKET_COUNT     = 4;
    localparam int TABLE_ROWS       = 4;
    localparam int MAX_SOCKET       = (SOCKET_COUNT < TABLE_ROWS) ? SOCKET_COUNT : TABLE_ROWS;
    localparam int DEF_LIST_LENGTH  = 4;
    localparam int DIGITS           = 12;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd350;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 4'd4;

    // Segment lengths in base periods
    localparam logic [PERIODS_W-1:0] LEN_SHORT  = 5'd1;
    localparam logic [PERIODS_W-1:0] LEN_LONG   = 5'd3;
    localparam logic [PERIODS_W-1:0] SYNC_LONG  = 5'd31;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 1'b0,
        CFG_REPEAT = 1'b1
    } t_cfg_reg;

    // Base-3 digits of each socket code, most significant digit at index 0.
    typedef logic [0:DIGITS-1][1:0] t_digit_word;

    // Rows are sockets 1..4; column 0 is the off code, column 1 the on code.
    localparam t_digit_word CODE_DIGITS [TABLE_ROWS][2] = '{
        '{ '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0},
           '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2} },
        '{ '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0},
           '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2} },
        '{ '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0},
           '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2} },
        '{ '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0},
           '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2} }
    };

    // A socket number is usable when it is nonzero and within the table.
    function automatic logic socket_ok(logic [SOCK_W-1:0] s);
        return (s != '0) && ({1'b0, s} <= (SOCK_W+1)'(MAX_SOCKET));
    endfunction

    // Table row of a usable socket number.
    function automatic logic [ROW_W-1:0] socket_row(logic [SOCK_W-1:0] s);
        logic [SOCK_W-1:0] r;
        r = s - SOCK_W'(1);
        return r[ROW_W-1:0];
    endfunction

    // Length in base periods of one segment; a digit index past the code means sync.
    function automatic logic [PERIODS_W-1:0] seg_periods(
        logic [ROW_W-1:0]       row,
        logic                   on,
        logic [DIGIT_IDX_W-1:0] didx,
        logic [SEG_W-1:0]       seg
    );
        logic [1:0]           d;
        logic [PERIODS_W-1:0] len;
        d   = 2'd0;
        len = LEN_SHORT;
        if (didx >= DIGIT_IDX_W'(DIGITS)) begin
            len = seg[0] ? SYNC_LONG : LEN_SHORT;
        end else begin
            d = CODE_DIGITS[row][on][didx];
            unique case (d)
                2'd0: len = seg[0] ? LEN_LONG : LEN_SHORT;
                2'd1: len = seg[0] ? LEN_SHORT : LEN_LONG;
                default: len = (seg == 2'd1 || seg == 2'd2) ? LEN_LONG : LEN_SHORT;
            endcase
        end
        return len;
    endfunction

endpackage

/* hdl/tristate_remote_switch_transmitter_core.sv */
// Tri-state remote switch transmitter core: load words latch a socket list, tick words
// step the keyed waveform. Depends on trst_pkg.
// Each result word is registered in the output stage, or in the skid entry while that stage is stalled.
// Throughput: one input word per cycle while the skid entry is empty; the state update for a word is a single pass.
// A two-entry output stage keeps the input ready while one result waits downstream.
// Reset (i_rst_n low, synchronous) clears the transmit state and output flags, sets period 350 and repeat 4.
module tristate_remote_switch_transmitter_core #(
    parameter int LIST_LENGTH = trst_pkg::DEF_LIST_LENGTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: socket_a[2:0], socket_b[5:3], socket_c[8:6], socket_d[11:9],
    //        switch_on[12], zero [15:13]
    input  logic [trst_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: opcode[0]
    input  logic                               i_s_tuser,
    // Result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: tx_level[0], led_level[1], busy_res[2], accepted[3], zero [7:4]
    output logic [trst_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [trst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [trst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int POS_W = $clog2(LIST_LENGTH + 1);
    localparam int IDX_W = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;

    localparam int SW  = trst_pkg::SOCK_W;
    localparam int PW  = trst_pkg::PERIOD_W;
    localparam int RW  = trst_pkg::REPEAT_W;
    localparam int LW  = trst_pkg::PERIODS_W;
    localparam int DW  = trst_pkg::DIGIT_IDX_W;
    localparam int GW  = trst_pkg::SEG_W;
    localparam int OW  = trst_pkg::OUT_TDATA_W;

    // Configuration registers
    logic [PW-1:0] r_period;
    logic [RW-1:0] r_repeat;

    // Transmit state
    logic          r_active,  n_active;
    logic          r_on,      n_on;
    logic [SW-1:0] r_list     [LIST_LENGTH];
    logic [SW-1:0] n_list     [LIST_LENGTH];
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [RW-1:0] r_rep,     n_rep;
    logic [DW-1:0] r_digit,   n_digit;
    logic [GW-1:0] r_seg,     n_seg;
    logic [LW-1:0] r_left,    n_left;
    logic [PW-1:0] r_tick,    n_tick;

    // Output stage and skid entry
    logic          r_out_valid;
    logic [OW-1:0] r_out_data;
    logic          r_skid_valid;
    logic [OW-1:0] r_skid_data;

    logic          in_take;
    logic          out_take;
    logic [OW-1:0] n_word;

    logic [SW-1:0] in_sock [trst_pkg::INPUT_SOCKETS];
    logic          in_on;
    logic          res_tx, res_led, res_acc;
    logic [PW-1:0] period_eff;
    logic [RW-1:0] repeat_eff;
    logic [PW:0]   tick_inc;
    logic [LW-1:0] left_dec;
    logic [RW-1:0] rep_dec;
    logic [SW-1:0] cur_sock;
    logic [SW-1:0] nxt_sock;
    logic [POS_W-1:0] pos_inc;
    logic [DW-1:0] adv_digit;
    logic [GW-1:0] adv_seg;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign in_take     = i_s_tvalid && o_s_tready;
    assign out_take    = r_out_valid && i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Unpack the load fields.
    always_comb begin
        for (int i = 0; i < trst_pkg::INPUT_SOCKETS; i++) begin
            in_sock[i] = i_s_tdata[i*SW +: SW];
        end
        in_on = i_s_tdata[trst_pkg::INPUT_SOCKETS*SW];
    end

    // Effective register values and current and next list entries.
    always_comb begin
        period_eff = (r_period == '0) ? PW'(1) : r_period;
        repeat_eff = (r_repeat == '0) ? RW'(1) : r_repeat;
        tick_inc   = {1'b0, r_tick} + (PW+1)'(1);
        left_dec   = (r_left != '0) ? (r_left - LW'(1)) : r_left;
        rep_dec    = (r_rep != '0) ? (r_rep - RW'(1)) : r_rep;
        pos_inc    = r_pos + POS_W'(1);
        cur_sock   = (r_pos < POS_W'(LIST_LENGTH)) ? r_list[r_pos[IDX_W-1:0]] : '0;
        nxt_sock   = (pos_inc < POS_W'(LIST_LENGTH)) ? r_list[pos_inc[IDX_W-1:0]] : '0;
        if (r_seg == GW'(3)) begin
            adv_digit = r_digit + DW'(1);
            adv_seg   = '0;
        end else begin
            adv_digit = r_digit;
            adv_seg   = r_seg + GW'(1);
        end
    end

    // Next state and result for the accepted word.
    always_comb begin
        n_active = r_active;
        n_on     = r_on;
        n_list   = r_list;
        n_pos    = r_pos;
        n_rep    = r_rep;
        n_digit  = r_digit;
        n_seg    = r_seg;
        n_left   = r_left;
        n_tick   = r_tick;
        res_tx   = 1'b0;
        res_led  = 1'b0;
        res_acc  = 1'b0;
        if (in_take) begin
            if (trst_pkg::t_opcode'(i_s_tuser) == trst_pkg::OP_LOAD) begin
                // A load is taken only while idle.
                if (!r_active) begin
                    for (int i = 0; i < LIST_LENGTH; i++) begin
                        n_list[i] = (i < trst_pkg::INPUT_SOCKETS) ? in_sock[2'(i)] : '0;
                    end
                    n_on    = in_on;
                    n_pos   = '0;
                    res_acc = 1'b1;
                    if (trst_pkg::socket_ok(in_sock[0])) begin
                        n_active = 1'b1;
                        n_rep    = repeat_eff;
                        n_digit  = '0;
                        n_seg    = '0;
                        n_tick   = '0;
                        n_left   = trst_pkg::seg_periods(trst_pkg::socket_row(in_sock[0]),
                                                         in_on, '0, '0);
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end else if (r_active) begin
                // One tick of the waveform: even segments are high.
                res_tx  = !r_seg[0];
                res_led = 1'b1;
                if (tick_inc >= {1'b0, period_eff}) begin
                    n_tick = '0;
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        if (r_digit < DW'(trst_pkg::DIGITS)) begin
                            // Next segment of a digit, or the first sync segment.
                            n_digit = adv_digit;
                            n_seg   = adv_seg;
                            n_left  = trst_pkg::seg_periods(trst_pkg::socket_row(cur_sock),
                                                            r_on, adv_digit, adv_seg);
                        end else if (r_seg == '0) begin
                            n_seg  = GW'(1);
                            n_left = trst_pkg::SYNC_LONG;
                        end else if (rep_dec != '0) begin
                            // Repeat the frame for the same socket.
                            n_rep   = rep_dec;
                            n_digit = '0;
                            n_seg   = '0;
                            n_left  = trst_pkg::seg_periods(trst_pkg::socket_row(cur_sock),
                                                            r_on, '0, '0);
                        end else begin
                            // Move on to the next socket or finish the list.
                            n_rep = rep_dec;
                            n_pos = pos_inc;
                            if (trst_pkg::socket_ok(nxt_sock)) begin
                                n_rep   = repeat_eff;
                                n_digit = '0;
                                n_seg   = '0;
                                n_left  = trst_pkg::seg_periods(
                                              trst_pkg::socket_row(nxt_sock), r_on, '0, '0);
                            end else begin
                                n_active = 1'b0;
                            end
                        end
                    end
                end else begin
                    n_tick = tick_inc[PW-1:0];
                end
            end
        end
        n_word = {(OW-4)'(0), res_acc, n_active, res_led, res_tx};
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= trst_pkg::PERIOD_RESET;
            r_repeat <= trst_pkg::REPEAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (trst_pkg::t_cfg_reg'(i_cfg_index))
                trst_pkg::CFG_PERIOD: r_period <= i_cfg_data[PW-1:0];
                trst_pkg::CFG_REPEAT: r_repeat <= i_cfg_data[RW-1:0];
            endcase
        end
    end

    // Transmit state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_on     <= 1'b0;
            for (int i = 0; i < LIST_LENGTH; i++) begin
                r_list[i] <= '0;
            end
            r_pos    <= '0;
            r_rep    <= '0;
            r_digit  <= '0;
            r_seg    <= '0;
            r_left   <= '0;
            r_tick   <= '0;
        end else begin
            r_active <= n_active;
            r_on     <= n_on;
            r_list   <= n_list;
            r_pos    <= n_pos;
            r_rep    <= n_rep;
            r_digit  <= n_digit;
            r_seg    <= n_seg;
            r_left   <= n_left;
            r_tick   <= n_tick;
        end
    end

    // Output word register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_take;
            end
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_word;
        end
        if (r_out_valid && !out_take && in_take) begin
            r_skid_data <= n_word;
        end
    end

endmodule

/* hdl/trst_checker.sv */
// Port-level checker for the tri-state remote switch transmitter core, bound to the core module.
// Depends on trst_pkg for port widths.
module trst_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [trst_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    // Input back-pressure only appears while a result word is already waiting.
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result word pending");

    // After every accepted word, the result stream shows a valid word on the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted word produced no result word");

    // A stalled result word holds its contents.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

    // A taken load spends no time: transmit and indicator stay low.
    a_load_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |-> (!o_m_tdata[0] && !o_m_tdata[1]))
        else $error("accepted load shows transmit activity");

    // The transmit pin is only driven while a socket is being sent.
    a_tx_needs_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> o_m_tdata[1])
        else $error("transmit level high with indicator low");

endmodule

bind tristate_remote_switch_transmitter_core trst_checker u_trst_checker (.*);

/* tb/tb_tristate_remote_switch_transmitter_core.sv */
// Self-checking testbench for tristate_remote_switch_transmitter_core: tick and load words
// go in, one result word per input is checked against a predictor of the keyed waveform.
// Depends on trst_pkg and the core; random stalls on both streams and register phases.
`timescale 1ns / 1ps

module tb_tristate_remote_switch_transmitter_core;

    localparam int CYCLE_LIMIT = 300000;

    // Fixed 20-bit socket codes: rows are sockets 1..4, column 0 off, column 1 on.
    localparam int unsigned SOCKET_CODES [4][2] = '{
        '{136320, 136316}, '{137292, 137288}, '{137616, 137612}, '{137724, 137720}
    };

    // Input word: socket_a in the lowest bits, then b, c, d, then switch_on.
    typedef struct packed {
        logic [2:0]      pad;
        logic            switch_on;
        logic [3:0][2:0] socket;
    } t_load_word;

    // Result word: tx_level in bit 0, then led_level, busy_res, accepted.
    typedef struct packed {
        logic [3:0] pad;
        logic       accepted;
        logic       busy_res;
        logic       led_level;
        logic       tx_level;
    } t_level_word;

    // Predicts the keyed levels of each accepted word and checks the result stream.
    class keying_scoreboard;
        logic [11:0]  period_reg;
        logic [3:0]   repeat_reg;
        bit           busy;
        bit           on_mode;
        logic [2:0]   sockets [4];
        int           pos;
        int           frames_left;
        int           digit;
        int           seg;
        int           periods;
        int           ticks;
        t_level_word  pending_levels [$];
        int           errors;
        int           checked;
        int           loads_taken;
        int           loads_refused;
        int           keyed_ticks;
        int           sockets_started;

        function new();
            period_reg = trst_pkg::PERIOD_RESET;
            repeat_reg = trst_pkg::REPEAT_RESET;
            busy = 0;
            on_mode = 0;
            foreach (sockets[i]) sockets[i] = '0;
            pos = 0;
            frames_left = 0;
            digit = 0;
            seg = 0;
            periods = 0;
            ticks = 0;
            errors = 0;
            checked = 0;
            loads_taken = 0;
            loads_refused = 0;
            keyed_ticks = 0;
            sockets_started = 0;
        endfunction

        function void write_reg(trst_pkg::t_cfg_reg idx, logic [11:0] val);
            if (idx == trst_pkg::CFG_PERIOD) period_reg = val;
            else repeat_reg = val[3:0];
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        // Base-3 digit of the current socket code, most significant digit first.
        function int unsigned code_digit();
            int unsigned code;
            code = SOCKET_CODES[sockets[pos] - 1][on_mode] & 32'hFFFFF;
            for (int k = digit; k < 11; k++) code = code / 3;
            return code % 3;
        endfunction

        // Length of the current segment in base periods; digit 12 is the sync.
        function void load_length();
            if (digit >= 12) begin
                periods = seg[0] ? 31 : 1;
            end else begin
                case (code_digit())
                    0: periods = seg[0] ? 3 : 1;
                    1: periods = seg[0] ? 1 : 3;
                    default: periods = (seg == 1 || seg == 2) ? 3 : 1;
                endcase
            end
            ticks = 0;
        endfunction

        function void begin_frame();
            digit = 0;
            seg = 0;
            load_length();
        endfunction

        // A zero or out-of-table socket number ends the list.
        function void begin_socket();
            if (pos >= 4 || sockets[pos] == 0 || sockets[pos] > 4) begin
                busy = 0;
            end else begin
                frames_left = (repeat_reg == 0) ? 1 : repeat_reg;
                sockets_started++;
                begin_frame();
            end
        endfunction

        function void next_segment();
            seg++;
            if (digit < 12) begin
                if (seg >= 4) begin
                    seg = 0;
                    digit++;
                end
                load_length();
            end else if (seg < 2) begin
                load_length();
            end else begin
                if (frames_left > 0) frames_left--;
                if (frames_left > 0) begin
                    begin_frame();
                end else begin
                    pos++;
                    begin_socket();
                end
            end
        endfunction

        // Work out the result word of one accepted input word.
        function void predict_levels(trst_pkg::t_opcode op, t_load_word w);
            t_level_word want;
            int          span;
            want = '0;
            span = (period_reg == 0) ? 1 : period_reg;
            if (op == trst_pkg::OP_LOAD) begin
                if (busy) begin
                    loads_refused++;
                end else begin
                    foreach (sockets[i]) sockets[i] = w.socket[i];
                    on_mode = w.switch_on;
                    pos = 0;
                    busy = 1;
                    begin_socket();
                    want.accepted = 1'b1;
                    loads_taken++;
                end
            end else if (busy) begin
                want.tx_level = !seg[0];
                want.led_level = 1'b1;
                keyed_ticks++;
                ticks++;
                if (ticks >= span) begin
                    ticks = 0;
                    if (periods > 0) periods--;
                    if (periods == 0) next_segment();
                end
            end
            want.busy_res = busy;
            pending_levels.push_back(want);
        endfunction

        // Compare one result word with the oldest prediction, field by field.
        function void check_levels(t_level_word got);
            t_level_word want;
            string       names [4];
            names = '{"tx_level", "led_level", "busy_res", "accepted"};
            if (pending_levels.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            checked++;
            for (int i = 0; i < 4; i++) begin
                if (got[i] !== want[i]) begin
                    $error("%s: expected %0b, got %0b", names[i], want[i], got[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    trst_pkg::t_opcode  s_tuser   = trst_pkg::OP_TICK;
    t_load_word         s_tdata   = '0;
    logic               m_tready  = 1'b0;
    logic               cfg_valid = 1'b0;
    trst_pkg::t_cfg_reg cfg_index = trst_pkg::CFG_PERIOD;
    logic [11:0]        cfg_data  = '0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    t_level_word        o_m_tdata;
    logic               o_cfg_ready;

    keying_scoreboard sb;
    bit               calm = 0;
    int               stall_left = 0;
    int               cycles = 0;

    tristate_remote_switch_transmitter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready most of the time, with random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_tready) sb.check_levels(o_m_tdata);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one word, sometimes after a gap, and wait for the handshake.
    task automatic send_word(input trst_pkg::t_opcode op, input t_load_word w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= w;
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_levels(op, w);
    endtask

    // Hold the sender off until every predicted word has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input trst_pkg::t_cfg_reg idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // The repeat write carries junk in the unused upper data bits.
    task automatic set_config(input logic [11:0] period, input logic [3:0] reps);
        write_reg(trst_pkg::CFG_PERIOD, period);
        write_reg(trst_pkg::CFG_REPEAT, {8'($urandom), reps});
        cfg_valid <= 1'b0;
    endtask

    function automatic t_load_word load_of(logic [2:0] a, logic [2:0] b, logic [2:0] c,
                                           logic [2:0] d, logic on);
        t_load_word w;
        w = '0;
        w.socket = {d, c, b, a};
        w.switch_on = on;
        return w;
    endfunction

    // Mostly ticks; loads are frequent while idle so lists keep restarting.
    // Loads refused while busy do not count toward the word total.
    task automatic run_random(input int count);
        t_load_word        w;
        trst_pkg::t_opcode op;
        int                sent;
        int                v;
        bit                refused;
        sent = 0;
        while (sent < count) begin
            w = '0;
            w.switch_on = 1'($urandom_range(0, 1));
            for (int i = 0; i < 4; i++) begin
                v = $urandom_range(0, 11);
                if (v < 9) w.socket[i] = 3'(v % 4 + 1);
                else if (v == 9) w.socket[i] = 3'd0;
                else w.socket[i] = 3'($urandom_range(5, 7));
            end
            if (sb.busy) begin
                op = ($urandom_range(0, 39) == 0) ? trst_pkg::OP_LOAD : trst_pkg::OP_TICK;
            end else begin
                op = ($urandom_range(0, 3) == 0) ? trst_pkg::OP_LOAD : trst_pkg::OP_TICK;
            end
            refused = (op == trst_pkg::OP_LOAD) && sb.busy;
            send_word(op, w);
            if (!refused) sent++;
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: idle tick, empty list, invalid first socket numbers.
        send_word(trst_pkg::OP_TICK, 16'hFFFF >> 3);
        send_word(trst_pkg::OP_LOAD, load_of(3'd0, 3'd3, 3'd2, 3'd1, 1'b0));
        send_word(trst_pkg::OP_LOAD, load_of(3'd5, 3'd1, 3'd0, 3'd0, 1'b1));
        send_word(trst_pkg::OP_LOAD, load_of(3'd7, 3'd6, 3'd0, 3'd0, 1'b1));
        send_word(trst_pkg::OP_TICK, '0);
        settle();

        // Longest period: a list starts, a second load is refused, the count builds up.
        set_config(12'd4095, 4'd1);
        send_word(trst_pkg::OP_LOAD, load_of(3'd4, 3'd1, 3'd0, 3'd0, 1'b1));
        send_word(trst_pkg::OP_LOAD, load_of(3'd2, 3'd3, 3'd0, 3'd0, 1'b0));
        repeat (12) send_word(trst_pkg::OP_TICK, '0);
        settle();

        // Shorter period ends the running one at once; the repeat of 15 waits for the
        // next socket, which this phase is too short to reach.
        set_config(12'd2, 4'd15);
        run_random(120);
        settle();

        // Zero period and zero repeat count each behave like one.
        set_config(12'd0, 4'd1);
        run_random(250);
        settle();
        set_config(12'd1, 4'd2);
        run_random(250);
        settle();
        set_config(12'd1, 4'd0);
        run_random(200);
        settle();

        // Back-to-back traffic with no stalls on either side.
        calm = 1;
        set_config(12'd1, 4'd1);
        run_random(250);
        settle();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d result words: %0d lists loaded, %0d loads refused while busy,",
                 sb.checked, sb.loads_taken, sb.loads_refused);
        $display("%0d sockets keyed over %0d busy ticks.", sb.sockets_started, sb.keyed_ticks);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
